@@ src/ffts_pkg.sv @@
// Shared types and constants for the two-stack FIFO.
// Used by the controller, the datapath and the top level; no dependencies.
package ffts_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;
   localparam int DATA_W              = 32;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_MOVE,
      S_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       take;
      logic       push;
      logic       pop;
      logic       move_start;
      logic       set_pend;
      status_type pend_status;
      logic       load_rsp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      opcode_type op;
      logic       in_full;
      logic       in_empty;
      logic       out_empty;
      logic       mv_done;
      logic       out_free;
   } stat_type;

endpackage

@@ src/ffts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ffts_ctrl.sv @@
// Request sequencer for the two-stack FIFO.
// Depends on ffts_pkg; drives the datapath through cmd_type, reads stat_type.
module ffts_ctrl
   import ffts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  opcode_type req_op,
   input  stat_type   st,
   output cmd_type    cmd
);

   state_type  state_ff;
   state_type  state_in;
   opcode_type op;
   logic       decide;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.pend_status = ST_OK;
      req_tready      = (state_ff == S_IDLE);
      op              = (state_ff == S_IDLE) ? req_op : st.op;
      decide          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               decide   = 1'b1;
            end
         end
         S_EXEC: begin
            decide = 1'b1;
         end
         S_MOVE: begin
            // come back and retry the held request once the stacks are swapped
            if (st.mv_done) begin
               state_in = S_EXEC;
            end
         end
         S_RESP: begin
            if (st.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (decide) begin
         if (op == OP_ENQUEUE) begin
            if (!st.in_full) begin
               cmd.push     = 1'b1;
               cmd.set_pend = 1'b1;
               state_in     = S_RESP;
            end else if (st.out_empty) begin
               cmd.move_start = 1'b1;
               state_in       = S_MOVE;
            end else begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_FULL;
               state_in        = S_RESP;
            end
         end else begin
            if (!st.out_empty) begin
               cmd.pop      = 1'b1;
               cmd.set_pend = 1'b1;
               state_in     = S_RESP;
            end else if (!st.in_empty) begin
               cmd.move_start = 1'b1;
               state_in       = S_MOVE;
            end else begin
               cmd.set_pend    = 1'b1;
               cmd.pend_status = ST_EMPTY;
               state_in        = S_RESP;
            end
         end
      end
   end

endmodule

@@ src/ffts_dpath.sv @@
// Datapath of the two-stack FIFO: both stack RAMs, counts, transfer pointers
// and the response register. Depends on ffts_pkg and ffts_ram.
module ffts_dpath
   import ffts_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  opcode_type        req_op,
   input  logic [DATA_W-1:0] req_value,
   input  cmd_type           cmd,
   output stat_type          st,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [DATA_W-1:0] rsp_data,
   output status_type        rsp_status
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [CW-1:0]     in_count_ff, in_count_in;
   logic [CW-1:0]     out_count_ff, out_count_in;
   opcode_type        op_ff;
   logic [DATA_W-1:0] val_ff;
   logic [DATA_W-1:0] cur_val;
   logic [AW-1:0]     rd_ptr_ff;
   logic [CW-1:0]     rd_left_ff;
   logic [AW-1:0]     wr_ptr_ff;
   logic              wr_pend_ff;
   status_type        pend_status_ff;
   logic              pend_pop_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] in_rdata;
   logic [DATA_W-1:0] out_rdata;
   logic [CW-1:0]     in_top;
   logic [CW-1:0]     out_top;
   logic              mv_rd;

   assign cur_val = cmd.take ? req_value : val_ff;
   assign in_top  = in_count_ff - CW'(1);
   assign out_top = out_count_ff - CW'(1);
   assign mv_rd   = (rd_left_ff != '0);

   ffts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_in_stack (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (in_count_ff[AW-1:0]),
      .wr_data (cur_val),
      .rd_en   (mv_rd),
      .rd_addr (rd_ptr_ff),
      .rd_data (in_rdata)
   );

   ffts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_out_stack (
      .clock   (clock),
      .wr_en   (wr_pend_ff),
      .wr_addr (wr_ptr_ff),
      .wr_data (in_rdata),
      .rd_en   (cmd.pop),
      .rd_addr (out_top[AW-1:0]),
      .rd_data (out_rdata)
   );

   always_comb begin
      in_count_in = in_count_ff;
      if (cmd.move_start) begin
         in_count_in = '0;
      end else if (cmd.push) begin
         in_count_in = in_count_ff + CW'(1);
      end
      out_count_in = out_count_ff;
      if (cmd.move_start) begin
         out_count_in = in_count_ff;
      end else if (cmd.pop) begin
         out_count_in = out_top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         rd_left_ff   <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         if (cmd.move_start) begin
            rd_left_ff <= in_count_ff;
            wr_pend_ff <= 1'b0;
         end else begin
            // read one word per cycle off the top, write it in the following cycle
            if (mv_rd) begin
               rd_left_ff <= rd_left_ff - CW'(1);
            end
            wr_pend_ff <= mv_rd;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_op;
         val_ff <= req_value;
      end
      if (cmd.move_start) begin
         rd_ptr_ff <= in_top[AW-1:0];
         wr_ptr_ff <= '0;
      end else begin
         if (mv_rd) begin
            rd_ptr_ff <= rd_ptr_ff - AW'(1);
         end
         if (wr_pend_ff) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
      end
      if (cmd.set_pend) begin
         pend_status_ff <= cmd.pend_status;
         pend_pop_ff    <= cmd.pop;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff   <= pend_pop_ff ? out_rdata : '0;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign st.op        = op_ff;
   assign st.in_full   = (in_count_ff == CW'(STACK_DEPTH));
   assign st.in_empty  = (in_count_ff == '0);
   assign st.out_empty = (out_count_ff == '0);
   assign st.mv_done   = !mv_rd && !wr_pend_ff;
   assign st.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ src/fifo_from_two_stacks.sv @@
// FIFO queue built from two stacks held in RAM.
// Request channel req_*: tuser[0] is the opcode (0 enqueue, 1 dequeue) and
// tdata carries the 32-bit word to enqueue (ignored on dequeue).
// Response channel rsp_*: one response per request, in request order;
// tdata is the dequeued word (zero for an enqueue or an error) and tuser is
// the status (0 ok, 1 full on enqueue, 2 empty on dequeue).
// A plain enqueue or dequeue passes through S_RESP, which loads the response
// register and raises rsp_tvalid once it is free; requests are taken one at
// a time, the next one only when the controller is back in S_IDLE.
// When a request must first move the input stack onto the empty output
// stack, the words are read off its top through the one read port of the
// input stack RAM into the output stack; each word moves at most once.
// A new request is accepted while the previous response still waits; if the
// receiver stalls, the next response waits inside the block and no further
// request is taken until the output register frees up.
// Reset clears both stack counts and the handshake state; stack contents
// are not cleared and need no clearing pass.
// Depends on ffts_pkg, ffts_ctrl, ffts_dpath and ffts_ram.
module fifo_from_two_stacks
   import ffts_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  logic [0:0]        req_tuser,   // [0] opcode
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [31:0] data_out
   output logic [1:0]        rsp_tuser    // [1:0] status
);

   cmd_type    cmd;
   stat_type   st;
   opcode_type req_op;
   status_type rsp_status;

   assign req_op = opcode_type'(req_tuser[0]);

   ffts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .st         (st),
      .cmd        (cmd)
   );

   ffts_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_op),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .st         (st),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_status)
   );

   assign rsp_tuser = rsp_status;

endmodule
